### sv/lsct_pkg.sv
// ----------------------------------------------------------------------------
// lsct_pkg
// Shared types, codes and helpers for the sector buffer tag and lock table.
// ----------------------------------------------------------------------------
package lsct_pkg;

    // table geometry
    localparam int SLOTS        = 16;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SECTOR_W     = 32;
    localparam int SLOT_FIELD_W = 4;
    localparam int IDX_W        = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
    localparam int LOCK_W       = 8;

    localparam logic [LOCK_W-1:0] LOCK_MAX = '1;

    // command codes
    localparam logic [1:0] CMD_LOOKUP  = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_FILL    = 2'd2;

    // status codes
    localparam logic [2:0] ST_HIT         = 3'd0;
    localparam logic [2:0] ST_FILL_NEEDED = 3'd1;
    localparam logic [2:0] ST_ALL_LOCKED  = 3'd2;
    localparam logic [2:0] ST_FILLED      = 3'd3;
    localparam logic [2:0] ST_FILL_FAILED = 3'd4;
    localparam logic [2:0] ST_RELEASED    = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd6;

    typedef logic [SLOT_W-1:0] t_slot_idx;

    typedef struct packed {
        logic [1:0]              command;
        logic [SECTOR_W-1:0]     sector;
        logic [SLOT_FIELD_W-1:0] fill_slot;
        logic                    fill_ok;
    } t_in_word;

    typedef struct packed {
        logic [2:0]              status;
        logic [SLOT_FIELD_W-1:0] slot;
    } t_out_word;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic      found;
        t_slot_idx idx;
    } t_find;

    // lowest set bit of a slot vector
    function automatic t_find find_first(input logic [SLOTS-1:0] v);
        t_find r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = SLOT_W'(i);
            end
        end
        return r;
    endfunction

    // low bits of a slot index for the result word
    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input t_slot_idx idx);
        logic [IDX_W-1:0] w;
        w = IDX_W'(idx);
        return w[SLOT_FIELD_W-1:0];
    endfunction

endpackage

### sv/lsct_ctrl.sv
// ----------------------------------------------------------------------------
// lsct_ctrl
// Sequencer: takes a word, runs the compare cycle, then the update cycle
// once the result register is free.
// ----------------------------------------------------------------------------
module lsct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output lsct_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       can_finish;
    logic       accept;

    // result register is free or being emptied this cycle
    assign can_finish = !(r_out_valid && i_out_stall);
    assign o_in_stall = !((r_state == S_IDLE) || ((r_state == S_UPD) && can_finish));
    assign accept     = i_in_valid && !o_in_stall;

    assign o_cmd.load    = accept;
    assign o_cmd.compare = (r_state == S_CMP);
    assign o_cmd.update  = (r_state == S_UPD) && can_finish;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (can_finish) n_state = accept ? S_CMP : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.update || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // no word taken while the compare cycle runs
    a_no_accept_in_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> !accept)
        else $error("word accepted during compare cycle");

    // a result appears only out of the update cycle
    a_result_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_UPD))
        else $error("result valid without update");

    // compare is always followed by update
    a_cmp_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_state == S_UPD))
        else $error("compare not followed by update");

endmodule

### sv/lsct_dp.sv
// ----------------------------------------------------------------------------
// lsct_dp
// Datapath: tag and lock registers, replace pointer, registered match
// vectors, slot selection and the result register.
// ----------------------------------------------------------------------------
module lsct_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsct_pkg::t_dp_cmd  i_cmd,
    input  lsct_pkg::t_in_word i_in_word,
    output lsct_pkg::t_out_word o_out_word
);

    logic [lsct_pkg::SECTOR_W-1:0] r_tag  [lsct_pkg::SLOTS];
    logic [lsct_pkg::SECTOR_W-1:0] n_tag  [lsct_pkg::SLOTS];
    logic [lsct_pkg::LOCK_W-1:0]   r_lock [lsct_pkg::SLOTS];
    logic [lsct_pkg::LOCK_W-1:0]   n_lock [lsct_pkg::SLOTS];
    lsct_pkg::t_slot_idx           r_ptr, n_ptr;
    lsct_pkg::t_in_word            r_item;
    lsct_pkg::t_out_word           r_out, n_out;
    logic [lsct_pkg::SLOTS-1:0]    r_hit_vec, r_rel_vec, r_free_vec;

    lsct_pkg::t_find               hit_f, rel_f, free_f;
    logic [lsct_pkg::SLOTS-1:0]    free_rot;
    logic [lsct_pkg::SLOT_W:0]     free_sum;
    lsct_pkg::t_slot_idx           free_idx;
    logic [lsct_pkg::IDX_W:0]      fill_wide;
    logic                          fill_in_range;
    lsct_pkg::t_slot_idx           fill_idx;

    // first hit and first locked match, from slot 0
    assign hit_f = lsct_pkg::find_first(r_hit_vec);
    assign rel_f = lsct_pkg::find_first(r_rel_vec);

    // first free slot at or after the replace pointer, wrapping
    assign free_rot = lsct_pkg::SLOTS'({r_free_vec, r_free_vec} >> r_ptr);
    assign free_f   = lsct_pkg::find_first(free_rot);
    assign free_sum = {1'b0, r_ptr} + {1'b0, free_f.idx};

    always_comb begin
        if (free_sum >= (lsct_pkg::SLOT_W + 1)'(lsct_pkg::SLOTS)) begin
            free_idx = lsct_pkg::SLOT_W'(free_sum - (lsct_pkg::SLOT_W + 1)'(lsct_pkg::SLOTS));
        end else begin
            free_idx = free_sum[lsct_pkg::SLOT_W-1:0];
        end
    end

    // fill slot range check
    assign fill_wide     = (lsct_pkg::IDX_W + 1)'(r_item.fill_slot);
    assign fill_in_range = fill_wide < (lsct_pkg::IDX_W + 1)'(lsct_pkg::SLOTS);
    assign fill_idx      = fill_wide[lsct_pkg::SLOT_W-1:0];

    // table update and result
    always_comb begin
        n_tag  = r_tag;
        n_lock = r_lock;
        n_ptr  = r_ptr;
        n_out  = r_out;
        if (i_cmd.update) begin
            unique case (r_item.command)
                lsct_pkg::CMD_LOOKUP: begin
                    if (hit_f.found) begin
                        if (r_lock[hit_f.idx] != lsct_pkg::LOCK_MAX) begin
                            n_lock[hit_f.idx] = r_lock[hit_f.idx] + 1'b1;
                        end
                        n_out.status = lsct_pkg::ST_HIT;
                        n_out.slot   = lsct_pkg::slot_field(hit_f.idx);
                    end else if (free_f.found) begin
                        n_lock[free_idx] = lsct_pkg::LOCK_W'(1);
                        n_tag[free_idx]  = '0;
                        if (free_idx == lsct_pkg::SLOT_W'(lsct_pkg::SLOTS - 1)) begin
                            n_ptr = '0;
                        end else begin
                            n_ptr = free_idx + 1'b1;
                        end
                        n_out.status = lsct_pkg::ST_FILL_NEEDED;
                        n_out.slot   = lsct_pkg::slot_field(free_idx);
                    end else begin
                        n_out.status = lsct_pkg::ST_ALL_LOCKED;
                        n_out.slot   = '0;
                    end
                end
                lsct_pkg::CMD_RELEASE: begin
                    if (rel_f.found) begin
                        n_lock[rel_f.idx] = r_lock[rel_f.idx] - 1'b1;
                        n_out.status      = lsct_pkg::ST_RELEASED;
                        n_out.slot        = lsct_pkg::slot_field(rel_f.idx);
                    end else begin
                        n_out.status = lsct_pkg::ST_NOT_FOUND;
                        n_out.slot   = '0;
                    end
                end
                lsct_pkg::CMD_FILL: begin
                    n_out.slot = r_item.fill_slot;
                    if (!fill_in_range) begin
                        n_out.status = lsct_pkg::ST_FILL_FAILED;
                    end else if (r_item.fill_ok) begin
                        n_tag[fill_idx] = r_item.sector;
                        n_out.status    = lsct_pkg::ST_FILLED;
                    end else begin
                        n_tag[fill_idx] = '0;
                        if (r_lock[fill_idx] != '0) begin
                            n_lock[fill_idx] = r_lock[fill_idx] - 1'b1;
                        end
                        n_out.status = lsct_pkg::ST_FILL_FAILED;
                    end
                end
                default: begin
                    n_out.status = lsct_pkg::ST_NOT_FOUND;
                    n_out.slot   = '0;
                end
            endcase
        end
    end

    // table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lsct_pkg::SLOTS; i++) begin
                r_tag[i]  <= '0;
                r_lock[i] <= '0;
            end
            r_ptr <= '0;
        end else begin
            r_tag  <= n_tag;
            r_lock <= n_lock;
            r_ptr  <= n_ptr;
        end
    end

    // captured word, match vectors and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_word;
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < lsct_pkg::SLOTS; i++) begin
                r_hit_vec[i]  <= (r_tag[i] == r_item.sector);
                r_rel_vec[i]  <= (r_tag[i] == r_item.sector) && (r_lock[i] != '0);
                r_free_vec[i] <= (r_lock[i] == '0);
            end
        end
        r_out <= n_out;
    end

    assign o_out_word = r_out;

endmodule

### sv/locked_sector_cache_tags.sv
// ----------------------------------------------------------------------------
// locked_sector_cache_tags
// Tag and lock table of a small sector buffer with round-robin placement.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry a command word (lookup,
// release or fill complete). Output channel: o_out_valid / i_out_stall
// carry one result word (status and slot) for every command word.
// A word is taken when valid is high and stall is low.
// Steps: the word is captured when taken, then the parallel tag and lock
// compares are registered, then the update cycle runs the priority scans,
// updates the table and loads the result register. No word is taken
// during the compare cycle; the next word is taken in the update cycle
// of the previous one, so the compare always sees the updated table.
// Receiver stall: the result register holds; the update waits until it
// is free and the input side stalls meanwhile.
// Reset: synchronous, active low; all tags and lock counts clear to zero
// and the replace pointer to slot 0 at once, no clearing pass.
// ----------------------------------------------------------------------------
module locked_sector_cache_tags (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lsct_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lsct_pkg::t_out_word o_out_word
);

    lsct_pkg::t_dp_cmd dp_cmd;

    // sequencer
    lsct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    // table and result datapath
    lsct_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule
